// ----- hw/rtl/cwg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cwg_pkg: shared types and constants of the rectangle window command generator
// Holds the configuration bundle, the queued window descriptor, the result
// item kinds, the panel opcodes and the sequencer step codes.
// ----------------------------------------------------------------------------
package cwg_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET    = 3'd3;

    localparam logic [7:0] RST_PANEL_WIDTH   = 8'd128;
    localparam logic [7:0] RST_PANEL_HEIGHT  = 8'd160;
    localparam logic [7:0] RST_COLUMN_OFFSET = 8'd0;
    localparam logic [7:0] RST_ROW_OFFSET    = 8'd0;

    localparam logic [7:0] OPC_COLUMN_SET = 8'h2A;
    localparam logic [7:0] OPC_ROW_SET    = 8'h2B;
    localparam logic [7:0] OPC_MEM_WRITE  = 8'h2C;

    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_FILL = 2'd2,
        KIND_BUF  = 2'd3
    } item_kind_t;

    typedef enum logic [3:0] {
        STEP_COL_CMD,
        STEP_COL_X0_HI,
        STEP_COL_X0,
        STEP_COL_X1_HI,
        STEP_COL_X1,
        STEP_ROW_CMD,
        STEP_ROW_Y0_HI,
        STEP_ROW_Y0,
        STEP_ROW_Y1_HI,
        STEP_ROW_Y1,
        STEP_MEM_WRITE,
        STEP_RUN
    } step_t;

    typedef struct packed {
        logic [7:0] panel_width;
        logic [7:0] panel_height;
        logic [7:0] column_offset;
        logic [7:0] row_offset;
    } cfg_t;

    // One clipped request, with the offsets already applied to the coordinates.
    typedef struct packed {
        logic        is_buf;
        logic [7:0]  x_first;
        logic [7:0]  x_last;
        logic [7:0]  y_first;
        logic [7:0]  y_last;
        logic [15:0] color;
        logic [15:0] count;
    } desc_t;

endpackage : cwg_pkg
`default_nettype wire

// ----- hw/rtl/clipped_rect_window_command_gen_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_rect_window_command_gen_top: clipped rectangle window command source
// Turns rectangle requests into panel address-window command streams.
// ----------------------------------------------------------------------------
// Each request is clipped against the configured panel size. A request whose
// start lies off the panel, or whose width or height is zero, produces no
// output and is absorbed without writing the queue. Any other request produces exactly
// twelve transfers on the m_ channel: column-set, 0, x0, 0, x1, row-set, 0,
// y0, 0, y1, memory-write, and one run item that carries the clipped pixel
// count and, for fill requests, the colour. Offsets are added to coordinates
// modulo 256. The front classifier accepts one request per cycle while the
// queue of FIFO_DEPTH descriptors has room; the back sequencer emits one
// transfer per cycle while the receiver is ready and loads the next descriptor
// as it issues the run item, so queued requests stream without gaps. An
// accepted request passes the queue, the descriptor register and the output
// register before its first transfer. The user must write the configuration
// registers through cfg_wr_en, cfg_index and cfg_wdata only while no request is
// in flight; the block does not enforce it. Indexes past the last register are ignored.
// ----------------------------------------------------------------------------
module clipped_rect_window_command_gen_top #(
    parameter int unsigned FIFO_DEPTH = 2
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [cwg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_req_type,
    input  wire logic [7:0]                    s_start_x,
    input  wire logic [7:0]                    s_start_y,
    input  wire logic [7:0]                    s_rect_width,
    input  wire logic [7:0]                    s_rect_height,
    input  wire logic [15:0]                   s_fill_color,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_item_kind,
    output logic [7:0]                         m_byte_value,
    output logic [15:0]                        m_run_color,
    output logic [15:0]                        m_pixel_count,
    output logic                               m_last_item
);

    cwg_pkg::cfg_t  cfg_reg;
    cwg_pkg::desc_t front_desc;
    cwg_pkg::desc_t q_data;
    logic           keep;
    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.panel_width   <= cwg_pkg::RST_PANEL_WIDTH;
            cfg_reg.panel_height  <= cwg_pkg::RST_PANEL_HEIGHT;
            cfg_reg.column_offset <= cwg_pkg::RST_COLUMN_OFFSET;
            cfg_reg.row_offset    <= cwg_pkg::RST_ROW_OFFSET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cwg_pkg::REG_PANEL_WIDTH:   cfg_reg.panel_width   <= cfg_wdata;
                cwg_pkg::REG_PANEL_HEIGHT:  cfg_reg.panel_height  <= cfg_wdata;
                cwg_pkg::REG_COLUMN_OFFSET: cfg_reg.column_offset <= cfg_wdata;
                cwg_pkg::REG_ROW_OFFSET:    cfg_reg.row_offset    <= cfg_wdata;
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The front takes a request whenever the queue has room; dropped requests
    // complete their transfer without writing the queue.
    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready && keep;

    cwg_front u_front (
        .s_req_type    (s_req_type),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_rect_width  (s_rect_width),
        .s_rect_height (s_rect_height),
        .s_fill_color  (s_fill_color),
        .cfg           (cfg_reg),
        .keep          (keep),
        .desc          (front_desc)
    );

    cwg_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (front_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    cwg_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item_kind   (m_item_kind),
        .m_byte_value  (m_byte_value),
        .m_run_color   (m_run_color),
        .m_pixel_count (m_pixel_count),
        .m_last_item   (m_last_item)
    );

endmodule : clipped_rect_window_command_gen_top
`default_nettype wire

// ----- hw/rtl/cwg_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cwg_front: request classifier and clipper
// Drops requests that start off the panel or are empty, clips the rest to the
// panel edge, applies the offsets and forms the pixel count.
// ----------------------------------------------------------------------------
module cwg_front (
    input  wire logic          s_req_type,
    input  wire logic [7:0]    s_start_x,
    input  wire logic [7:0]    s_start_y,
    input  wire logic [7:0]    s_rect_width,
    input  wire logic [7:0]    s_rect_height,
    input  wire logic [15:0]   s_fill_color,
    input  wire cwg_pkg::cfg_t cfg,
    output logic               keep,
    output cwg_pkg::desc_t     desc
);

    logic [8:0] x_sum;
    logic [8:0] y_sum;
    logic [7:0] w_clip;
    logic [7:0] h_clip;
    logic [7:0] x_end;
    logic [7:0] y_end;

    assign keep = (s_start_x < cfg.panel_width) && (s_start_y < cfg.panel_height)
                  && (s_rect_width != 8'd0) && (s_rect_height != 8'd0);

    assign x_sum = {1'b0, s_start_x} + {1'b0, s_rect_width} - 9'd1;
    assign y_sum = {1'b0, s_start_y} + {1'b0, s_rect_height} - 9'd1;

    always_comb begin
        if (x_sum >= {1'b0, cfg.panel_width}) begin
            w_clip = cfg.panel_width - s_start_x;
            x_end  = cfg.panel_width - 8'd1;
        end else begin
            w_clip = s_rect_width;
            x_end  = x_sum[7:0];
        end
        if (y_sum >= {1'b0, cfg.panel_height}) begin
            h_clip = cfg.panel_height - s_start_y;
            y_end  = cfg.panel_height - 8'd1;
        end else begin
            h_clip = s_rect_height;
            y_end  = y_sum[7:0];
        end
    end

    // Coordinate bytes wrap modulo 256 after the offset is added.
    always_comb begin
        desc.is_buf  = s_req_type;
        desc.x_first = s_start_x + cfg.column_offset;
        desc.x_last  = x_end + cfg.column_offset;
        desc.y_first = s_start_y + cfg.row_offset;
        desc.y_last  = y_end + cfg.row_offset;
        desc.color   = s_fill_color;
        desc.count   = {8'd0, w_clip} * {8'd0, h_clip};
    end

endmodule : cwg_front
`default_nettype wire

// ----- hw/rtl/cwg_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cwg_fifo: descriptor queue
// A small first-in first-out queue of window descriptors between the
// classifier and the command sequencer.
// ----------------------------------------------------------------------------
module cwg_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire cwg_pkg::desc_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output cwg_pkg::desc_t      pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cwg_pkg::desc_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule : cwg_fifo
`default_nettype wire

// ----- hw/rtl/cwg_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cwg_back: command sequencer
// Steps through the eleven window bytes and the run item of one descriptor,
// one result per cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module cwg_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_not_empty,
    input  wire cwg_pkg::desc_t q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [1:0]          m_item_kind,
    output logic [7:0]          m_byte_value,
    output logic [15:0]         m_run_color,
    output logic [15:0]         m_pixel_count,
    output logic                m_last_item
);

    cwg_pkg::desc_t cur_reg;
    logic           active_reg, active_next;
    cwg_pkg::step_t step_reg, step_next;
    logic           adv;

    logic                   m_valid_reg, m_valid_next;
    cwg_pkg::item_kind_t    kind_next;
    logic [7:0]             byte_next;
    logic [15:0]            color_next;
    logic [15:0]            count_next;
    logic                   last_next;
    logic [1:0]             kind_reg;
    logic [7:0]             byte_reg;
    logic [15:0]            color_reg;
    logic [15:0]            count_reg;
    logic                   last_reg;

    // A step advances whenever the output stage is empty or being drained.
    assign adv   = active_reg && (!m_valid_reg || m_ready);
    // Load the next descriptor when idle or while issuing the run item.
    assign q_pop = q_not_empty && (!active_reg || (adv && step_reg == cwg_pkg::STEP_RUN));

    always_comb begin
        active_next = active_reg;
        step_next   = step_reg;
        if (adv) begin
            case (step_reg)
                cwg_pkg::STEP_COL_CMD:   step_next = cwg_pkg::STEP_COL_X0_HI;
                cwg_pkg::STEP_COL_X0_HI: step_next = cwg_pkg::STEP_COL_X0;
                cwg_pkg::STEP_COL_X0:    step_next = cwg_pkg::STEP_COL_X1_HI;
                cwg_pkg::STEP_COL_X1_HI: step_next = cwg_pkg::STEP_COL_X1;
                cwg_pkg::STEP_COL_X1:    step_next = cwg_pkg::STEP_ROW_CMD;
                cwg_pkg::STEP_ROW_CMD:   step_next = cwg_pkg::STEP_ROW_Y0_HI;
                cwg_pkg::STEP_ROW_Y0_HI: step_next = cwg_pkg::STEP_ROW_Y0;
                cwg_pkg::STEP_ROW_Y0:    step_next = cwg_pkg::STEP_ROW_Y1_HI;
                cwg_pkg::STEP_ROW_Y1_HI: step_next = cwg_pkg::STEP_ROW_Y1;
                cwg_pkg::STEP_ROW_Y1:    step_next = cwg_pkg::STEP_MEM_WRITE;
                cwg_pkg::STEP_MEM_WRITE: step_next = cwg_pkg::STEP_RUN;
                default: begin
                    step_next   = cwg_pkg::STEP_COL_CMD;
                    active_next = 1'b0;
                end
            endcase
        end
        if (q_pop) begin
            active_next = 1'b1;
            step_next   = cwg_pkg::STEP_COL_CMD;
        end
    end

    always_comb begin
        kind_next  = cwg_pkg::KIND_DATA;
        byte_next  = 8'd0;
        color_next = 16'd0;
        count_next = 16'd0;
        last_next  = 1'b0;
        case (step_reg)
            cwg_pkg::STEP_COL_CMD: begin
                kind_next = cwg_pkg::KIND_CMD;
                byte_next = cwg_pkg::OPC_COLUMN_SET;
            end
            cwg_pkg::STEP_COL_X0:    byte_next = cur_reg.x_first;
            cwg_pkg::STEP_COL_X1:    byte_next = cur_reg.x_last;
            cwg_pkg::STEP_ROW_CMD: begin
                kind_next = cwg_pkg::KIND_CMD;
                byte_next = cwg_pkg::OPC_ROW_SET;
            end
            cwg_pkg::STEP_ROW_Y0:    byte_next = cur_reg.y_first;
            cwg_pkg::STEP_ROW_Y1:    byte_next = cur_reg.y_last;
            cwg_pkg::STEP_MEM_WRITE: begin
                kind_next = cwg_pkg::KIND_CMD;
                byte_next = cwg_pkg::OPC_MEM_WRITE;
            end
            cwg_pkg::STEP_RUN: begin
                kind_next  = cur_reg.is_buf ? cwg_pkg::KIND_BUF : cwg_pkg::KIND_FILL;
                color_next = cur_reg.is_buf ? 16'd0 : cur_reg.color;
                count_next = cur_reg.count;
                last_next  = 1'b1;
            end
            default: byte_next = 8'd0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            step_reg    <= cwg_pkg::STEP_COL_CMD;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
        if (adv) begin
            kind_reg  <= kind_next;
            byte_reg  <= byte_next;
            color_reg <= color_next;
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_item_kind   = kind_reg;
    assign m_byte_value  = byte_reg;
    assign m_run_color   = color_reg;
    assign m_pixel_count = count_reg;
    assign m_last_item   = last_reg;

endmodule : cwg_back
`default_nettype wire

// ----- hw/rtl/cwg_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cwg_checker: port-level checks for the window command generator
// Watches the result channel for handshake holding and item consistency.
// ----------------------------------------------------------------------------
module cwg_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_item_kind,
    input wire logic [7:0]  m_byte_value,
    input wire logic [15:0] m_run_color,
    input wire logic [15:0] m_pixel_count,
    input wire logic        m_last_item
);

    // A stalled transfer stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped while stalled");

    // A stalled transfer keeps its payload.
    a_hold_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_item_kind) && $stable(m_byte_value)
            && $stable(m_pixel_count) && $stable(m_run_color))
        else $error("result payload changed while stalled");

    // Only run items close a request, and every run item does.
    a_last_on_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_item == m_item_kind[1]))
        else $error("last flag does not match run item");

    // Byte items carry no colour or count, run items carry no byte.
    a_byte_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item_kind[1] ? (m_byte_value == 8'd0)
                                    : (m_run_color == 16'd0 && m_pixel_count == 16'd0)))
        else $error("unused result fields are not zero");

    // A buffer run carries no colour, and a run is never empty.
    a_run_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item_kind[1] |-> (m_pixel_count != 16'd0)
            && (!m_item_kind[0] || m_run_color == 16'd0))
        else $error("run item fields are inconsistent");

endmodule : cwg_checker

bind clipped_rect_window_command_gen_top cwg_checker u_cwg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_item_kind   (m_item_kind),
    .m_byte_value  (m_byte_value),
    .m_run_color   (m_run_color),
    .m_pixel_count (m_pixel_count),
    .m_last_item   (m_last_item)
);
`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for clipped_rect_window_command_gen_top
// Drives rectangle requests through the s_ channel under several panel sizes
// and offsets, predicts the twelve-transfer address-window stream of every
// request that survives clipping, and compares each m_ transfer against it
// while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    // One rectangle request as it travels on the s_ channel.
    typedef struct packed {
        logic        is_buf;
        logic [7:0]  start_x;
        logic [7:0]  start_y;
        logic [7:0]  rect_width;
        logic [7:0]  rect_height;
        logic [15:0] fill_color;
    } rect_req_t;

    // One transfer of the address-window stream as the block should emit it.
    typedef struct packed {
        cwg_pkg::item_kind_t kind;
        logic [7:0]          octet;
        logic [15:0]         color;
        logic [15:0]         count;
        logic                last_flag;
    } window_item_t;

    logic                          aclk;
    logic                          aresetn       = 1'b0;
    logic                          cfg_wr_en     = 1'b0;
    logic [cwg_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [7:0]                    cfg_wdata     = '0;
    logic                          s_valid       = 1'b0;
    logic                          s_ready;
    logic                          s_req_type    = 1'b0;
    logic [7:0]                    s_start_x     = '0;
    logic [7:0]                    s_start_y     = '0;
    logic [7:0]                    s_rect_width  = '0;
    logic [7:0]                    s_rect_height = '0;
    logic [15:0]                   s_fill_color  = '0;
    logic                          m_valid;
    logic                          m_ready       = 1'b0;
    logic [1:0]                    m_item_kind;
    logic [7:0]                    m_byte_value;
    logic [15:0]                   m_run_color;
    logic [15:0]                   m_pixel_count;
    logic                          m_last_item;

    // Requests waiting to be offered, and the transfers still owed by the block.
    rect_req_t    request_backlog[$];
    window_item_t window_items_due[$];
    rect_req_t    next_request;

    // Our own copy of the panel registers, updated as they are written.
    cwg_pkg::cfg_t window_cfg;

    // Percentages of cycles in which the sender holds back and the receiver stalls.
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;

    int unsigned requests_accepted = 0;
    int unsigned windows_predicted = 0;
    int unsigned transfers_checked = 0;
    int unsigned mismatches        = 0;

    clipped_rect_window_command_gen_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_rect_width  (s_rect_width),
        .s_rect_height (s_rect_height),
        .s_fill_color  (s_fill_color),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item_kind   (m_item_kind),
        .m_byte_value  (m_byte_value),
        .m_run_color   (m_run_color),
        .m_pixel_count (m_pixel_count),
        .m_last_item   (m_last_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard limit on the run, set far above the length of the slowest legal run.
    initial begin
        #2000000;
        $display("FAIL clipped_rect_window_command_gen_top");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Window stream predictor
    // ------------------------------------------------------------------------

    function automatic void push_item(input cwg_pkg::item_kind_t kind,
                                      input logic [7:0] octet,
                                      input logic [15:0] color, input logic [15:0] count,
                                      input logic last_flag);
        window_item_t item;
        item.kind      = kind;
        item.octet     = octet;
        item.color     = color;
        item.count     = count;
        item.last_flag = last_flag;
        window_items_due.push_back(item);
    endfunction

    // A set command followed by its two 16-bit coordinates, high bytes zero.
    // The offset add wraps modulo 256.
    function automatic void push_coord_pair(input logic [7:0] opcode, input int first,
                                            input int final_coord, input logic [7:0] offset);
        logic [7:0] first_b;
        logic [7:0] last_b;
        first_b = 8'(first + int'(offset));
        last_b  = 8'(final_coord + int'(offset));
        push_item(cwg_pkg::KIND_CMD, opcode, 16'h0000, 16'h0000, 1'b0);
        push_item(cwg_pkg::KIND_DATA, 8'h00, 16'h0000, 16'h0000, 1'b0);
        push_item(cwg_pkg::KIND_DATA, first_b, 16'h0000, 16'h0000, 1'b0);
        push_item(cwg_pkg::KIND_DATA, 8'h00, 16'h0000, 16'h0000, 1'b0);
        push_item(cwg_pkg::KIND_DATA, last_b, 16'h0000, 16'h0000, 1'b0);
    endfunction

    // Clip one accepted request against the panel and queue the transfers it owes.
    function automatic void expand_request(input rect_req_t req);
        int          cols;
        int          rows;
        int          x_end;
        int          y_end;
        logic [15:0] count;
        // Starts off the panel and empty rectangles produce nothing. A zero
        // panel size puts every start off the panel.
        if (req.start_x >= window_cfg.panel_width || req.start_y >= window_cfg.panel_height)
            return;
        if (req.rect_width == 8'd0 || req.rect_height == 8'd0)
            return;
        cols  = int'(req.rect_width);
        rows  = int'(req.rect_height);
        x_end = int'(req.start_x) + cols - 1;
        y_end = int'(req.start_y) + rows - 1;
        // A rectangle that reaches the panel edge is cut off at the last column or row.
        if (x_end >= int'(window_cfg.panel_width)) begin
            cols  = int'(window_cfg.panel_width) - int'(req.start_x);
            x_end = int'(window_cfg.panel_width) - 1;
        end
        if (y_end >= int'(window_cfg.panel_height)) begin
            rows  = int'(window_cfg.panel_height) - int'(req.start_y);
            y_end = int'(window_cfg.panel_height) - 1;
        end
        count = 16'(cols * rows);
        windows_predicted++;
        push_coord_pair(cwg_pkg::OPC_COLUMN_SET, int'(req.start_x), x_end,
                        window_cfg.column_offset);
        push_coord_pair(cwg_pkg::OPC_ROW_SET, int'(req.start_y), y_end,
                        window_cfg.row_offset);
        push_item(cwg_pkg::KIND_CMD, cwg_pkg::OPC_MEM_WRITE, 16'h0000, 16'h0000, 1'b0);
        if (req.is_buf) begin
            push_item(cwg_pkg::KIND_BUF, 8'h00, 16'h0000, count, 1'b1);
        end else begin
            push_item(cwg_pkg::KIND_FILL, 8'h00, req.fill_color, count, 1'b1);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers the backlog on the s_ channel, holding back at random.
    // A new request is only loaded when the channel is empty or the current
    // one transfers at this edge, so valid and payload stay put until taken.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_request   = request_backlog.pop_front();
                s_valid       <= 1'b1;
                s_req_type    <= next_request.is_buf;
                s_start_x     <= next_request.start_x;
                s_start_y     <= next_request.start_y;
                s_rect_width  <= next_request.rect_width;
                s_rect_height <= next_request.rect_height;
                s_fill_color  <= next_request.fill_color;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // The receiver stalls at random; with a zero percentage it is always ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks every m_ transfer against the oldest owed transfer, then
    // expands every s_ transfer into the transfers it will owe. The check comes
    // first, since a result never shares an edge with its own request.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                transfers_checked++;
                if (window_items_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: unexpected transfer kind %0d byte %h ",
                                  "color %h count %0d last %b"},
                                 m_item_kind, m_byte_value, m_run_color, m_pixel_count,
                                 m_last_item);
                end else begin
                    window_item_t due;
                    due = window_items_due.pop_front();
                    if (m_item_kind !== due.kind || m_byte_value !== due.octet ||
                        m_run_color !== due.color || m_pixel_count !== due.count ||
                        m_last_item !== due.last_flag) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: expected kind %0d byte %h color %h ",
                                      "count %0d last %b, got kind %0d byte %h ",
                                      "color %h count %0d last %b"},
                                     due.kind, due.octet, due.color, due.count,
                                     due.last_flag, m_item_kind, m_byte_value,
                                     m_run_color, m_pixel_count, m_last_item);
                    end
                end
            end
            if (s_valid && s_ready) begin
                rect_req_t taken;
                taken.is_buf      = s_req_type;
                taken.start_x     = s_start_x;
                taken.start_y     = s_start_y;
                taken.rect_width  = s_rect_width;
                taken.rect_height = s_rect_height;
                taken.fill_color  = s_fill_color;
                requests_accepted++;
                expand_request(taken);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------------

    function automatic void queue_request(input logic is_buf, input logic [7:0] x,
                                          input logic [7:0] y, input logic [7:0] w,
                                          input logic [7:0] h, input logic [15:0] color);
        rect_req_t req;
        req.is_buf      = is_buf;
        req.start_x     = x;
        req.start_y     = y;
        req.rect_width  = w;
        req.rect_height = h;
        req.fill_color  = color;
        request_backlog.push_back(req);
    endfunction

    task automatic write_reg(input logic [cwg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            cwg_pkg::REG_PANEL_WIDTH:   window_cfg.panel_width   = value;
            cwg_pkg::REG_PANEL_HEIGHT:  window_cfg.panel_height  = value;
            cwg_pkg::REG_COLUMN_OFFSET: window_cfg.column_offset = value;
            cwg_pkg::REG_ROW_OFFSET:    window_cfg.row_offset    = value;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Writes all four registers and returns at a falling edge, so that requests
    // queued right after never race the driver.
    task automatic set_panel(input logic [7:0] pw, input logic [7:0] ph,
                             input logic [7:0] col_off, input logic [7:0] row_off);
        write_reg(cwg_pkg::REG_PANEL_WIDTH, pw);
        write_reg(cwg_pkg::REG_PANEL_HEIGHT, ph);
        write_reg(cwg_pkg::REG_COLUMN_OFFSET, col_off);
        write_reg(cwg_pkg::REG_ROW_OFFSET, row_off);
        @(negedge aclk);
    endtask

    // Waits until every request is taken and every owed transfer has arrived.
    // The classifier keeps no state, so no dropped request is left behind once the
    // backlog and s_valid are empty; the task still waits before the registers change.
    task automatic wait_for_drain();
        @(negedge aclk);
        while (request_backlog.size() != 0 || s_valid || window_items_due.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Picks a panel dimension: often the largest, sometimes tiny, else anything.
    function automatic logic [7:0] pick_panel_size();
        case ($urandom_range(3))
            0:       return 8'd255;
            1:       return 8'($urandom_range(1, 8));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Small sizes half of the time, which exercise clipping near the start, and
    // any size otherwise, which clip at the panel edge.
    function automatic logic [7:0] pick_extent();
        if ($urandom_range(1))
            return 8'($urandom_range(1, 16));
        return 8'($urandom_range(1, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned phase;
        int unsigned n;
        logic [7:0]  rx;
        logic [7:0]  ry;

        window_cfg.panel_width   = cwg_pkg::RST_PANEL_WIDTH;
        window_cfg.panel_height  = cwg_pkg::RST_PANEL_HEIGHT;
        window_cfg.column_offset = cwg_pkg::RST_COLUMN_OFFSET;
        window_cfg.row_offset    = cwg_pkg::RST_ROW_OFFSET;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, first with the registers as reset left them (128 x 160).
        queue_request(1'b0, 8'd0, 8'd0, 8'd255, 8'd255, 16'hFFFF);   // clipped both ways
        queue_request(1'b1, 8'd0, 8'd0, 8'd1, 8'd1, 16'h1234);       // buffer ignores colour
        queue_request(1'b0, 8'd127, 8'd159, 8'd1, 8'd1, 16'h0000);   // last visible pixel
        queue_request(1'b0, 8'd128, 8'd0, 8'd5, 8'd5, 16'h0F0F);     // start just right of panel
        queue_request(1'b0, 8'd0, 8'd160, 8'd5, 8'd5, 16'hF0F0);     // start just below panel
        queue_request(1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
        queue_request(1'b0, 8'd10, 8'd10, 8'd0, 8'd5, 16'h1111);     // zero width
        queue_request(1'b1, 8'd10, 8'd10, 8'd5, 8'd0, 16'h2222);     // zero height
        queue_request(1'b0, 8'd100, 8'd0, 8'd28, 8'd1, 16'hAAAA);    // ends on the edge
        queue_request(1'b0, 8'd100, 8'd0, 8'd29, 8'd160, 16'h5555);  // one column past it
        queue_request(1'b1, 8'd3, 8'd7, 8'd200, 8'd100, 16'h8001);
        wait_for_drain();

        // Widest panel with the largest offsets: full-size counts and coordinate wrap.
        set_panel(8'd255, 8'd255, 8'd255, 8'd255);
        queue_request(1'b0, 8'd0, 8'd0, 8'd255, 8'd255, 16'hFFFF);
        queue_request(1'b1, 8'd254, 8'd254, 8'd255, 8'd255, 16'h0000);
        queue_request(1'b0, 8'd254, 8'd0, 8'd1, 8'd255, 16'h7FFE);
        wait_for_drain();

        // Single-pixel panel.
        set_panel(8'd1, 8'd1, 8'd0, 8'd0);
        queue_request(1'b0, 8'd0, 8'd0, 8'd1, 8'd1, 16'hC3C3);
        queue_request(1'b1, 8'd0, 8'd0, 8'd255, 8'd255, 16'h3C3C);
        queue_request(1'b0, 8'd1, 8'd0, 8'd1, 8'd1, 16'h0001);
        queue_request(1'b0, 8'd0, 8'd1, 8'd1, 8'd1, 16'h8000);
        wait_for_drain();

        // Zero panel size: nothing can land on the panel.
        set_panel(8'd0, 8'd0, 8'd17, 8'd33);
        queue_request(1'b0, 8'd0, 8'd0, 8'd1, 8'd1, 16'h4242);
        queue_request(1'b1, 8'd0, 8'd0, 8'd255, 8'd255, 16'h2424);
        wait_for_drain();

        // Random part: eight phases cycling through the idling modes, each with
        // its own panel setting. Most requests start on the panel with a
        // non-zero size; the rest are fully random and often dropped.
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 51; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 51; end
                default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
            endcase
            set_panel(pick_panel_size(), pick_panel_size(),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
            for (n = 0; n < 32; n++) begin
                if ($urandom_range(99) < 85) begin
                    rx = 8'($urandom_range(int'(window_cfg.panel_width) - 1));
                    ry = 8'($urandom_range(int'(window_cfg.panel_height) - 1));
                    queue_request(1'($urandom_range(1)), rx, ry, pick_extent(), pick_extent(),
                                  16'($urandom_range(65535)));
                end else begin
                    queue_request(1'($urandom_range(1)), 8'($urandom_range(255)),
                                  8'($urandom_range(255)), 8'($urandom_range(255)),
                                  8'($urandom_range(255)), 16'($urandom_range(65535)));
                end
            end
            wait_for_drain();
        end

        // Everything has drained; allow a little more time for stray transfers.
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (16) @(posedge aclk);

        $display("Ran %0d requests over 12 panel settings, %0d of them inside the panel.",
                 requests_accepted, windows_predicted);
        $display("Checked %0d output transfers, %0d mismatches.", transfers_checked, mismatches);
        if (mismatches == 0 && window_items_due.size() == 0) begin
            $display("PASS clipped_rect_window_command_gen_top");
        end else begin
            $display("FAIL clipped_rect_window_command_gen_top");
        end
        $finish;
    end

endmodule : testbench
